FILE: design/ipd_pkg.sv
// shared types and constants for the incremental pid with deadband
package ipd_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR  = 3'd5;

   // divisor comes out of reset as 1.0 in q16.16
   localparam logic [31:0] DIVISOR_RESET = 32'h0001_0000;

   // datapath operation selected by the control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_WAIT,
      OP_ERR,
      OP_LDX,
      OP_MAC,
      OP_ACC,
      OP_LDT,
      OP_DIVI,
      OP_DIVS,
      OP_FIN
   } op_type;

   // sequencer branch kinds
   typedef enum logic [2:0] {
      J_NEXT,
      J_INPUT,
      J_NODIV,
      J_LOOP,
      J_OUTPUT,
      J_GOTO
   } jmp_type;

   // which gain term a load step sets up
   typedef enum logic [1:0] {
      TERM_I,
      TERM_P,
      TERM_D
   } term_type;

   typedef struct packed {
      op_type     op;
      term_type   term;
      jmp_type    jmp;
      logic [4:0] target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic div_zero;
      logic out_free;
   } seq_status_type;

   typedef struct packed {
      logic [31:0] gain_p;
      logic [31:0] gain_i;
      logic [31:0] gain_d;
      logic [31:0] setpoint;
      logic [30:0] deadband;
      logic [31:0] divisor;
   } cfg_type;

endpackage

FILE: design/ipd_if.sv
// request and response channel interfaces
interface ipd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] measurement;
   logic        [15:0] interval;

   modport source (output valid, output measurement, output interval, input ready);
   modport sink (input valid, input measurement, input interval, output ready);
endinterface

interface ipd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] increment;
   logic signed [47:0] total;
   logic               saturated;

   modport source (output valid, output increment, output total, output saturated,
                   input ready);
   modport sink (input valid, input increment, input total, input saturated,
                 output ready);
endinterface

FILE: design/ipd_csr.sv
// configuration register bank
module ipd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ipd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ipd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ipd_pkg::cfg_type                   cfg
);

   ipd_pkg::cfg_type cfg_ff;
   ipd_pkg::cfg_type cfg_in;

   // decode the write, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ipd_pkg::CSR_GAIN_P:   cfg_in.gain_p   = csr_wdata;
            ipd_pkg::CSR_GAIN_I:   cfg_in.gain_i   = csr_wdata;
            ipd_pkg::CSR_GAIN_D:   cfg_in.gain_d   = csr_wdata;
            ipd_pkg::CSR_SETPOINT: cfg_in.setpoint = csr_wdata;
            ipd_pkg::CSR_DEADBAND: cfg_in.deadband = csr_wdata[30:0];
            ipd_pkg::CSR_DIVISOR:  cfg_in.divisor  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gain_p: '0, gain_i: '0, gain_d: '0, setpoint: '0, deadband: '0,
                     divisor: ipd_pkg::DIVISOR_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/ipd_seq.sv
// microcode sequencer: step counter, control rom and branch logic
module ipd_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  ipd_pkg::seq_status_type sts,
   output ipd_pkg::ctrl_type       ctrl
);

   localparam logic [4:0] PC_START = 5'd0;
   localparam logic [4:0] PC_ERR   = 5'd1;
   localparam logic [4:0] PC_DIVS  = 5'd23;
   localparam logic [4:0] PC_FIN   = 5'd24;
   localparam logic [5:0] DIV_LAST = 6'd47;

   logic [4:0] pc_ff;
   logic [4:0] pc_in;
   logic [5:0] cnt_ff;
   logic [5:0] cnt_in;

   // control program, one word per step
   function automatic ipd_pkg::ctrl_type ucode(input logic [4:0] pc);
      ipd_pkg::ctrl_type w;
      case (pc) inside
         5'd0:  w = '{ipd_pkg::OP_WAIT, ipd_pkg::TERM_I, ipd_pkg::J_INPUT, PC_START};
         5'd1:  w = '{ipd_pkg::OP_ERR,  ipd_pkg::TERM_I, ipd_pkg::J_NEXT,  PC_START};
         5'd2:  w = '{ipd_pkg::OP_LDX,  ipd_pkg::TERM_I, ipd_pkg::J_NEXT,  PC_START};
         5'd7:  w = '{ipd_pkg::OP_LDX,  ipd_pkg::TERM_P, ipd_pkg::J_NEXT,  PC_START};
         5'd12: w = '{ipd_pkg::OP_LDX,  ipd_pkg::TERM_D, ipd_pkg::J_NEXT,  PC_START};
         [5'd3:5'd5], [5'd8:5'd10], [5'd13:5'd15], [5'd18:5'd21]:
            w = '{ipd_pkg::OP_MAC, ipd_pkg::TERM_I, ipd_pkg::J_NEXT, PC_START};
         5'd6, 5'd11, 5'd16:
            w = '{ipd_pkg::OP_ACC, ipd_pkg::TERM_I, ipd_pkg::J_NEXT, PC_START};
         5'd17: w = '{ipd_pkg::OP_LDT,  ipd_pkg::TERM_I, ipd_pkg::J_NEXT,   PC_START};
         5'd22: w = '{ipd_pkg::OP_DIVI, ipd_pkg::TERM_I, ipd_pkg::J_NODIV,  PC_FIN};
         5'd23: w = '{ipd_pkg::OP_DIVS, ipd_pkg::TERM_I, ipd_pkg::J_LOOP,   PC_DIVS};
         5'd24: w = '{ipd_pkg::OP_FIN,  ipd_pkg::TERM_I, ipd_pkg::J_OUTPUT, PC_START};
         default: w = '{ipd_pkg::OP_NOP, ipd_pkg::TERM_I, ipd_pkg::J_GOTO, PC_START};
      endcase
      return w;
   endfunction

   // rom read
   always_comb begin
      ctrl = ucode(pc_ff);
   end

   // next step and loop counter
   always_comb begin
      pc_in  = pc_ff + 5'd1;
      cnt_in = cnt_ff;
      case (ctrl.jmp)
         ipd_pkg::J_NEXT: pc_in = pc_ff + 5'd1;
         ipd_pkg::J_INPUT: begin
            if (!sts.req_valid) pc_in = pc_ff;
         end
         ipd_pkg::J_NODIV: begin
            if (sts.div_zero) begin
               pc_in = ctrl.target;
            end else begin
               cnt_in = DIV_LAST;
            end
         end
         ipd_pkg::J_LOOP: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 6'd1;
               pc_in  = ctrl.target;
            end
         end
         ipd_pkg::J_OUTPUT: pc_in = sts.out_free ? ctrl.target : pc_ff;
         ipd_pkg::J_GOTO:   pc_in = ctrl.target;
         default:           pc_in = PC_START;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= PC_START;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   // an accepted request always starts the error step
   a_start: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_START && sts.req_valid) |=> pc_ff == PC_ERR)
      else $error("accepted request did not start the program");

   // loop count is only live inside the divide loop
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> pc_ff == PC_DIVS)
      else $error("loop counter live outside divide loop");

endmodule

FILE: design/ipd_dp.sv
// datapath: error, shared multiply-accumulate, divider and output register
module ipd_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  ipd_pkg::ctrl_type       ctrl,
   input  ipd_pkg::cfg_type        cfg,
   output ipd_pkg::seq_status_type sts,
   ipd_req_if.sink                 req_ch,
   ipd_rsp_if.source               rsp_ch
);

   localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SAT_NEG = 48'h8000_0000_0000;

   // payload registers
   logic [31:0] meas_ff,     meas_in;
   logic [15:0] ticks_ff,    ticks_in;
   logic [32:0] e_ff,        e_in;
   logic [31:0] a_ff,        a_in;
   logic [63:0] opnd_ff,     opnd_in;
   logic [71:0] acc_ff,      acc_in;
   logic        term_neg_ff, term_neg_in;
   logic [53:0] sum_ff,      sum_in;
   logic        sum_neg_ff,  sum_neg_in;
   logic        over_ff,     over_in;
   logic [31:0] rem_ff,      rem_in;
   logic [47:0] quo_ff,      quo_in;
   logic [47:0] rsp_inc_ff,  rsp_inc_in;
   logic [47:0] rsp_tot_ff,  rsp_tot_in;
   logic        rsp_sat_ff,  rsp_sat_in;

   // state registers
   logic [32:0] e1_ff,        e1_in;
   logic [32:0] e2_ff,        e2_in;
   logic [47:0] total_ff,     total_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [32:0] err_raw;
   logic [32:0] err_mag;
   logic [32:0] err_dz;
   logic [35:0] xe;
   logic [35:0] xe1;
   logic [35:0] xe2;
   logic [35:0] x_sel;
   logic [35:0] x_mag;
   logic [31:0] g_sel;
   logic [31:0] g_mag;
   logic [47:0] prod;
   logic [53:0] term_ext;
   logic [53:0] term_val;
   logic [53:0] sum_mag;
   logic [31:0] d_mag;
   logic        div_zero;
   logic [32:0] div_trial;
   logic [32:0] div_diff;
   logic        div_ge;
   logic [47:0] m_sel;
   logic        over_sel;
   logic        neg_f;
   logic [47:0] lim;
   logic        clip_inc;
   logic [47:0] m_c;
   logic [47:0] inc_val;
   logic [48:0] tsum;
   logic        clip_tot;
   logic [47:0] tot_val;
   logic        out_free;

   // error with deadband
   always_comb begin
      err_raw = {meas_ff[31], meas_ff} - {cfg.setpoint[31], cfg.setpoint};
      err_mag = err_raw[32] ? (~err_raw + 33'd1) : err_raw;
      err_dz  = (err_mag < {2'd0, cfg.deadband}) ? '0 : err_raw;
   end

   // term operands: gain and error combination, as magnitudes
   always_comb begin
      xe  = {{3{e_ff[32]}}, e_ff};
      xe1 = {{3{e1_ff[32]}}, e1_ff};
      xe2 = {{3{e2_ff[32]}}, e2_ff};
      case (ctrl.term)
         ipd_pkg::TERM_I: begin
            x_sel = xe;
            g_sel = cfg.gain_i;
         end
         ipd_pkg::TERM_P: begin
            x_sel = xe - xe1;
            g_sel = cfg.gain_p;
         end
         ipd_pkg::TERM_D: begin
            x_sel = xe + xe2 - {xe1[34:0], 1'b0};
            g_sel = cfg.gain_d;
         end
         default: begin
            x_sel = xe;
            g_sel = cfg.gain_i;
         end
      endcase
      x_mag = x_sel[35] ? (~x_sel + 36'd1) : x_sel;
      g_mag = g_sel[31] ? (~g_sel + 32'd1) : g_sel;
   end

   // shared 32x16 multiplier, top digit of the operand first
   assign prod = a_ff * opnd_ff[63:48];

   // truncated term with sign, and running sum magnitude
   always_comb begin
      term_ext = {3'd0, acc_ff[66:16]};
      term_val = term_neg_ff ? (~term_ext + 54'd1) : term_ext;
      sum_mag  = sum_ff[53] ? (~sum_ff + 54'd1) : sum_ff;
   end

   // restoring divide step
   always_comb begin
      d_mag     = cfg.divisor[31] ? (~cfg.divisor + 32'd1) : cfg.divisor;
      div_zero  = (cfg.divisor == '0);
      div_trial = {rem_ff, quo_ff[47]};
      div_ge    = (div_trial >= {1'b0, d_mag});
      div_diff  = div_trial - {1'b0, d_mag};
   end

   // increment clip, sign, and saturating total
   always_comb begin
      m_sel    = div_zero ? acc_ff[47:0] : quo_ff;
      over_sel = div_zero ? (acc_ff[71:48] != '0) : over_ff;
      neg_f    = sum_neg_ff ^ (!div_zero && cfg.divisor[31]);
      lim      = neg_f ? SAT_NEG : SAT_POS;
      clip_inc = over_sel || (m_sel > lim);
      m_c      = clip_inc ? lim : m_sel;
      inc_val  = neg_f ? (~m_c + 48'd1) : m_c;
      tsum     = {total_ff[47], total_ff} + {inc_val[47], inc_val};
      clip_tot = (tsum[48] != tsum[47]);
      if (clip_tot) begin
         tot_val = tsum[48] ? SAT_NEG : SAT_POS;
      end else begin
         tot_val = tsum[47:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // next values per control word
   always_comb begin
      meas_in      = meas_ff;
      ticks_in     = ticks_ff;
      e_in         = e_ff;
      a_in         = a_ff;
      opnd_in      = opnd_ff;
      acc_in       = acc_ff;
      term_neg_in  = term_neg_ff;
      sum_in       = sum_ff;
      sum_neg_in   = sum_neg_ff;
      over_in      = over_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_inc_in   = rsp_inc_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_sat_in   = rsp_sat_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (ctrl.op)
         ipd_pkg::OP_WAIT: begin
            if (req_ch.valid) begin
               meas_in  = req_ch.measurement;
               ticks_in = req_ch.interval;
            end
         end
         ipd_pkg::OP_ERR: begin
            e_in   = err_dz;
            sum_in = '0;
         end
         ipd_pkg::OP_LDX: begin
            a_in        = g_mag;
            opnd_in     = {12'd0, x_mag, 16'd0};
            acc_in      = '0;
            term_neg_in = g_sel[31] ^ x_sel[35];
         end
         ipd_pkg::OP_MAC: begin
            acc_in  = {acc_ff[55:0], 16'd0} + {24'd0, prod};
            opnd_in = {opnd_ff[47:0], 16'd0};
         end
         ipd_pkg::OP_ACC: sum_in = sum_ff + term_val;
         ipd_pkg::OP_LDT: begin
            sum_neg_in = sum_ff[53];
            opnd_in    = {10'd0, sum_mag};
            a_in       = {16'd0, ticks_ff};
            acc_in     = '0;
            e1_in      = e_ff;
            e2_in      = e1_ff;
         end
         ipd_pkg::OP_DIVI: begin
            over_in = (acc_ff[67:32] >= {4'd0, d_mag});
            rem_in  = acc_ff[63:32];
            quo_in  = {acc_ff[31:0], 16'd0};
         end
         ipd_pkg::OP_DIVS: begin
            rem_in = div_ge ? div_diff[31:0] : div_trial[31:0];
            quo_in = {quo_ff[46:0], div_ge};
         end
         ipd_pkg::OP_FIN: begin
            if (out_free) begin
               rsp_inc_in   = inc_val;
               rsp_tot_in   = tot_val;
               rsp_sat_in   = clip_inc || clip_tot;
               total_in     = tot_val;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // payload flops
   always_ff @(posedge clock) begin
      meas_ff     <= meas_in;
      ticks_ff    <= ticks_in;
      e_ff        <= e_in;
      a_ff        <= a_in;
      opnd_ff     <= opnd_in;
      acc_ff      <= acc_in;
      term_neg_ff <= term_neg_in;
      sum_ff      <= sum_in;
      sum_neg_ff  <= sum_neg_in;
      over_ff     <= over_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_inc_ff  <= rsp_inc_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // error history, running total and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff        <= '0;
         e2_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e1_ff        <= e1_in;
         e2_ff        <= e2_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // channel and status hookup
   assign req_ch.ready     = (ctrl.op == ipd_pkg::OP_WAIT);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.increment = rsp_inc_ff;
   assign rsp_ch.total     = rsp_tot_ff;
   assign rsp_ch.saturated = rsp_sat_ff;
   assign sts = '{req_valid: req_ch.valid, div_zero: div_zero, out_free: out_free};

   // a new response only comes from the final step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == ipd_pkg::OP_FIN))
      else $error("response raised outside final step");

   // partial remainder stays below the divisor
   a_rem: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == ipd_pkg::OP_DIVS && !over_ff && !div_zero) |-> (rem_ff < d_mag))
      else $error("divide remainder out of range");

   // total only moves when the response register takes a result
   a_total: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == ipd_pkg::OP_FIN && !out_free) |=> $stable(total_ff))
      else $error("total changed while response stalled");

endmodule

FILE: design/incremental_pid_deadband.sv
// incremental pid step with deadband, q16.16 in and q32.16 out
// requests are taken one at a time, through the shared 32x16 multiply-accumulate
//   and the 48-step restoring divider, which is skipped when the divisor is zero
// reset: synchronous, clears error history, running total and response valid;
//   registers return to zero gains and setpoint, zero deadband, divisor 1.0
module incremental_pid_deadband (
   input  logic                           clock,
   input  logic                           reset,
   ipd_req_if.sink                        req_ch,
   ipd_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [ipd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ipd_pkg::cfg_type        cfg;
   ipd_pkg::ctrl_type       ctrl;
   ipd_pkg::seq_status_type sts;

   // configuration registers
   ipd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // control sequencer
   ipd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctrl  (ctrl)
   );

   // arithmetic datapath
   ipd_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg),
      .sts    (sts),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: bench/ipd_output_checker.sv
// scoreboard that models the pid step and checks every response against it
module ipd_output_checker (
   input  logic                           clock,
   input  logic                           reset,
   ipd_req_if                             req_mon,
   ipd_rsp_if                             rsp_mon,
   input  logic                           csr_we,
   input  logic [ipd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             outstanding,
   output int                             checked_count,
   output int                             clipped_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [47:0] increment;
      logic signed [47:0] total;
      logic               saturated;
   } pid_output_type;

   // clip points of a 48 bit signed q32.16 value
   localparam logic [127:0]        INC_POS_LIMIT = 128'h7FFF_FFFF_FFFF;
   localparam logic [127:0]        INC_NEG_LIMIT = 128'h8000_0000_0000;
   localparam logic signed [63:0]  TOTAL_MAX     = 64'sh7FFF_FFFF_FFFF;
   localparam logic signed [63:0]  TOTAL_MIN     = -(64'sh8000_0000_0000);

   // shadow copy of the registers and the loop state
   logic signed [31:0] gain_p, gain_i, gain_d, setpoint, divisor;
   logic        [30:0] deadband;
   logic signed [32:0] last_err, older_err;
   logic signed [47:0] acc_total;
   pid_output_type     pending_outputs [$];
   pid_output_type     want;

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // q16.16 gain times error, shifted down by 16 and truncated toward zero
   function automatic logic signed [63:0] gain_product(logic signed [31:0] gain,
                                                       logic signed [63:0] x);
      logic signed [63:0] g64;
      logic        [127:0] prod;
      logic signed [63:0] q;
      g64  = gain;
      prod = {64'd0, abs64(g64)} * {64'd0, abs64(x)};
      q    = prod[79:16];
      return ((gain < 0) != (x < 0)) ? -q : q;
   endfunction

   // one control step: error, three gain terms, interval scaling, division, clipping
   function automatic pid_output_type next_pid_output(logic signed [31:0] meas,
                                                      logic        [15:0] ticks);
      logic signed [63:0] m64, sp64, err, prev, prev2, sum, dv64, inc, acc64, tot;
      logic        [127:0] scaled, limit;
      logic               neg;
      pid_output_type     r;
      m64  = meas;
      sp64 = setpoint;
      err  = m64 - sp64;
      // strict test: an error equal to the deadband survives
      if (abs64(err) < {33'd0, deadband}) err = '0;
      prev  = last_err;
      prev2 = older_err;
      sum = gain_product(gain_i, err) + gain_product(gain_p, err - prev)
          + gain_product(gain_d, err + prev2 - 2 * prev);
      older_err = last_err;
      last_err  = err[32:0];
      neg    = (sum < 0);
      scaled = {64'd0, abs64(sum)} * {112'd0, ticks};
      // zero divisor leaves the scaled increment undivided
      if (divisor != 0) begin
         dv64   = divisor;
         scaled = (scaled << 16) / {64'd0, abs64(dv64)};
         if (divisor < 0) neg = !neg;
      end
      limit       = neg ? INC_NEG_LIMIT : INC_POS_LIMIT;
      r.saturated = 1'b0;
      if (scaled > limit) begin
         r.saturated = 1'b1;
         scaled      = limit;
      end
      inc = scaled[63:0];
      if (neg) inc = -inc;
      // running total clips and holds at the rails
      acc64 = acc_total;
      tot   = acc64 + inc;
      if (tot > TOTAL_MAX) begin
         tot         = TOTAL_MAX;
         r.saturated = 1'b1;
      end else if (tot < TOTAL_MIN) begin
         tot         = TOTAL_MIN;
         r.saturated = 1'b1;
      end
      acc_total   = tot[47:0];
      r.increment = inc[47:0];
      r.total     = tot[47:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gain_p    = '0;
         gain_i    = '0;
         gain_d    = '0;
         setpoint  = '0;
         deadband  = '0;
         divisor   = ipd_pkg::DIVISOR_RESET;
         last_err  = '0;
         older_err = '0;
         acc_total = '0;
         pending_outputs.delete();
      end else begin
         // compare a delivered response with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_outputs.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: increment %0d total %0d saturated %0b",
                           rsp_mon.increment, rsp_mon.total, rsp_mon.saturated);
               fail_count++;
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_mon.increment !== want.increment || rsp_mon.total !== want.total ||
                   rsp_mon.saturated !== want.saturated) begin
                  if (fail_count < 10) begin
                     $display("mismatch on response %0d: increment exp %0d got %0d",
                              checked_count, want.increment, rsp_mon.increment);
                     $display("   total exp %0d got %0d, saturated exp %0b got %0b",
                              want.total, rsp_mon.total, want.saturated,
                              rsp_mon.saturated);
                  end
                  fail_count++;
               end
               checked_count++;
               if (want.saturated) clipped_count++;
            end
         end
         // register writes land at this edge, unknown indexes are dropped
         if (csr_we) begin
            case (csr_index)
               ipd_pkg::CSR_GAIN_P:   gain_p   = csr_wdata;
               ipd_pkg::CSR_GAIN_I:   gain_i   = csr_wdata;
               ipd_pkg::CSR_GAIN_D:   gain_d   = csr_wdata;
               ipd_pkg::CSR_SETPOINT: setpoint = csr_wdata;
               ipd_pkg::CSR_DEADBAND: deadband = csr_wdata[30:0];
               ipd_pkg::CSR_DIVISOR:  divisor  = csr_wdata;
               default: ;
            endcase
         end
         // predict the response of each accepted request
         if (req_mon.valid && req_mon.ready)
            pending_outputs.push_back(next_pid_output(req_mon.measurement, req_mon.interval));
      end
      outstanding = pending_outputs.size();
   end

endmodule

FILE: bench/tb_incremental_pid_deadband.sv
// top of the incremental pid regression: clock, reset, stimulus and verdict
module tb_incremental_pid_deadband;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes beyond the register map, writes there must be ignored
   localparam logic [ipd_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [ipd_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [31:0]                   Q_ONE        = 32'h0001_0000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we;
   logic [ipd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ipd_pkg::CSR_DATA_W-1:0] csr_wdata;

   int          fail_count, outstanding, checked_count, clipped_count;
   int          requests_sent, settings_applied, hold_requests;
   int unsigned req_idle_pct, rsp_idle_pct;

   ipd_req_if req_bus ();
   ipd_rsp_if rsp_bus ();

   incremental_pid_deadband u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ipd_output_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .clipped_count (clipped_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side: random stalls, or a long hold-off when asked
   initial begin
      int seen_holds;
      int hold_left;
      seen_holds    = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != seen_holds) begin
            seen_holds = hold_requests;
            hold_left  = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic write_register(input logic [ipd_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [31:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic configure(input logic [31:0] gp, gi, gd, sp, db, dv);
      write_register(ipd_pkg::CSR_GAIN_P, gp);
      write_register(ipd_pkg::CSR_GAIN_I, gi);
      write_register(ipd_pkg::CSR_GAIN_D, gd);
      write_register(ipd_pkg::CSR_SETPOINT, sp);
      write_register(ipd_pkg::CSR_DEADBAND, db);
      write_register(ipd_pkg::CSR_DIVISOR, dv);
      settings_applied++;
   endtask

   // offer one request, with an optional gap first, and hold it until taken
   task automatic send_request(input logic [31:0] meas, input logic [15:0] ticks);
      if ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(80, 1)) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.measurement = meas;
      req_bus.interval    = ticks;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // stop offering and wait for every predicted response
   task automatic drain();
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] random_gain();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(9))
         0:       return 32'h0;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return r;
         default: return {{12{r[19]}}, r[19:0]};
      endcase
   endfunction

   // one random register setting followed by a burst of requests
   task automatic run_random_phase(input int count, input bit with_hold);
      logic [31:0] r, sp, db, dv, meas, db_eff;
      logic [15:0] ticks;
      r = $urandom();
      case ($urandom_range(3))
         0:       sp = 32'h0;
         1:       sp = r;
         default: sp = {{12{r[19]}}, r[19:0]};
      endcase
      r = $urandom();
      case ($urandom_range(5))
         0:       db = 32'h0;
         1:       db = r;
         2:       db = 32'h7FFF_FFFF;
         default: db = {14'd0, r[17:0]};
      endcase
      r = $urandom();
      case ($urandom_range(9))
         0:       dv = 32'h0;
         1:       dv = Q_ONE;
         2:       dv = 32'hFFFF_0000;
         3:       dv = 32'h8000_0000;
         4:       dv = 32'h7FFF_FFFF;
         5:       dv = 32'h1;
         6:       dv = r;
         default: dv = {{14{r[17]}}, r[17:0]};
      endcase
      configure(random_gain(), random_gain(), random_gain(), sp, db, dv);
      db_eff = {1'b0, db[30:0]};
      // receiver stops taking responses while requests keep coming
      if (with_hold) begin
         @(posedge clock);
         hold_requests++;
         @(negedge clock);
      end
      for (int n = 0; n < count; n++) begin
         r = $urandom();
         case ($urandom_range(11))
            0, 1, 2, 3: meas = sp + {{14{r[17]}}, r[17:0]};
            4:          meas = sp + db_eff;
            5:          meas = sp - db_eff;
            6:          meas = 32'h7FFF_FFFF;
            7:          meas = 32'h8000_0000;
            default:    meas = r;
         endcase
         r = $urandom();
         case ($urandom_range(9))
            0:             ticks = 16'h0000;
            1:             ticks = 16'hFFFF;
            2, 3, 4, 5, 6: ticks = 16'($urandom_range(64, 1));
            default:       ticks = r[15:0];
         endcase
         send_request(meas, ticks);
      end
      drain();
   endtask

   // stimulus and verdict
   initial begin
      req_bus.valid       = 1'b0;
      req_bus.measurement = '0;
      req_bus.interval    = '0;
      csr_we              = 1'b0;
      csr_index           = ipd_pkg::CSR_GAIN_P;
      csr_wdata           = '0;
      req_idle_pct        = 19;
      rsp_idle_pct        = 86;
      hold_requests       = 0;
      requests_sent       = 0;
      settings_applied    = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset values: zero gains, divisor of one, field extremes
      send_request(32'h7FFF_FFFF, 16'hFFFF);
      send_request(32'h8000_0000, 16'h0000);
      drain();

      // spare indexes, then error at the deadband edge and a zero interval
      write_register(CSR_SPARE_LO, 32'hFFFF_FFFF);
      write_register(CSR_SPARE_HI, 32'h1234_5678);
      configure(Q_ONE, 32'h0000_8000, 32'hFFFF_C000, Q_ONE, 32'h0002_0000, Q_ONE);
      send_request(32'h0003_0000, 16'd5);
      send_request(32'h0002_FFFF, 16'd5);
      send_request(32'hFFFF_0000, 16'd7);
      send_request(32'h0001_0000, 16'd0);
      send_request(32'h0040_0000, 16'hFFFF);
      drain();

      // zero divisor: scaled increment passes undivided
      configure(32'h0002_0000, 32'hFFFF_0000, 32'h0000_4000, 32'h0, 32'h0, 32'h0);
      send_request(32'h0005_0000, 16'd3);
      send_request(32'hFFF0_0000, 16'd100);
      send_request(32'h0000_0001, 16'hFFFF);
      drain();

      // negative divisors, the most negative one included
      configure(Q_ONE, Q_ONE, Q_ONE, 32'h0, 32'h0, 32'h8000_0000);
      send_request(32'h1000_0000, 16'd9);
      send_request(32'hF000_0000, 16'hFFFF);
      drain();
      configure(Q_ONE, Q_ONE, Q_ONE, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_request(32'h0000_0100, 16'd2);
      send_request(32'h0001_0000, 16'd1);
      drain();

      // increment overflow, then the total pinned at each rail
      configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1);
      repeat (4) send_request(32'h7FFF_FFFF, 16'hFFFF);
      drain();
      configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h1);
      repeat (4) send_request(32'h7FFF_FFFF, 16'hFFFF);
      drain();

      // random settings under three stall profiles
      for (int p = 0; p < 15; p++) begin
         if (p < 5) begin
            req_idle_pct = 19;
            rsp_idle_pct = 86;
         end else if (p < 10) begin
            req_idle_pct = 86;
            rsp_idle_pct = 19;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_random_phase(50, (p == 2) || (p == 12));
      end

      drain();
      repeat (80) @(negedge clock);
      $display("run covered %0d requests over %0d register settings, %0d responses checked",
               requests_sent, settings_applied, checked_count);
      $display("%0d responses clipped; deadband edges, zero and negative divisors, long stall",
               clipped_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("incremental_pid_deadband regression: pass");
      end else begin
         $display("incremental_pid_deadband regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(10_000_000);
      $display("incremental_pid_deadband regression: fail");
      $finish;
   end

endmodule
